@@ rtl/acta_pkg.sv @@
package acta_pkg;

   localparam int SLOT_COUNT = 3;
   localparam int SLOT_W     = 2;
   localparam int CHAN_BITS  = 4;
   localparam int RAW_BITS   = 12;
   localparam int CNT_BITS   = 32;
   localparam int CSR_IDX_W  = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_C = 2'd2;

   localparam logic [CHAN_BITS-1:0] SLOT_A_RESET = 4'd4;
   localparam logic [CHAN_BITS-1:0] SLOT_B_RESET = 4'd6;
   localparam logic [CHAN_BITS-1:0] SLOT_C_RESET = 4'd0;

   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_FLUSH  = 1'b1
   } acta_op_type;

   typedef struct packed {
      acta_op_type          opcode;
      logic [CHAN_BITS-1:0] channel;
      logic [RAW_BITS-1:0]  sample_value;
   } acta_req_type;

   typedef struct packed {
      logic                triple_valid;
      logic [RAW_BITS-1:0] first_raw;
      logic [RAW_BITS-1:0] second_raw;
      logic [RAW_BITS-1:0] third_raw;
      logic                sample_rejected;
      logic                oldest_dropped;
      logic [CNT_BITS-1:0] samples_seen;
      logic [CNT_BITS-1:0] rejected_total;
      logic [CNT_BITS-1:0] anomaly_total;
   } acta_rsp_type;

endpackage

@@ rtl/acta_ram.sv @@
module acta_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/adc_channel_triple_aligner.sv @@
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    acta_req_type: opcode, channel, sample_value
// rsp      out        rsp_valid/stall    acta_rsp_type: one result word per request word
// csr      in         csr_valid/ready    csr_index, csr_data (slot channel numbers)
//
// One request word is taken per clock while req is not stalled; each gives exactly one
// result word after it is taken (slot RAM read, then the output register).
// Throughput is set by the single pointer/level update per cycle; the RAM read
// and the output register overlap with the next words.
// Reset clears pointers, fill levels, counters and pipeline valids; the RAM contents
// are not cleared, and no entry's read data is used before the entry is written.
// When rsp is stalled one more word is taken into the RAM read stage, then req stalls.
module adc_channel_triple_aligner
   import acta_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  acta_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output acta_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CHAN_BITS-1:0] csr_data
);

   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int LVL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_BITS = (SAMPLE_BITS < RAW_BITS) ? SAMPLE_BITS : RAW_BITS;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   logic [CHAN_BITS-1:0] slot_a_ff, slot_b_ff, slot_c_ff;

   logic [PTR_W-1:0] rd_ptr_ff [SLOT_COUNT];
   logic [PTR_W-1:0] rd_ptr_in [SLOT_COUNT];
   logic [PTR_W-1:0] wr_ptr_ff [SLOT_COUNT];
   logic [PTR_W-1:0] wr_ptr_in [SLOT_COUNT];
   logic [LVL_W-1:0] level_ff  [SLOT_COUNT];
   logic [LVL_W-1:0] level_in  [SLOT_COUNT];

   logic [CNT_BITS-1:0] sample_cnt_ff, sample_cnt_in;
   logic [CNT_BITS-1:0] reject_cnt_ff, reject_cnt_in;
   logic [CNT_BITS-1:0] anomaly_cnt_ff, anomaly_cnt_in;

   logic                  s1_valid_ff;
   logic                  s1_triple_ff;
   logic                  s1_reject_ff;
   logic                  s1_drop_ff;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic [STORE_BITS-1:0] s1_sample_ff;
   logic                  s2_valid_ff;
   acta_rsp_type          s2_data_ff;

   logic                  accept;
   logic                  advance_s2;
   logic                  is_sample;
   logic                  hit;
   logic [SLOT_W-1:0]     slot;
   logic                  full;
   logic                  triple;
   logic                  drop;
   logic [STORE_BITS-1:0] sample;
   logic [STORE_BITS-1:0] head_q [SLOT_COUNT];
   logic [RAW_BITS-1:0]   raw    [SLOT_COUNT];

   // Two-entry pipeline: the RAM read stage may fill while the output word waits.
   assign advance_s2 = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance_s2;
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = s2_valid_ff;
   assign rsp_data   = s2_data_ff;
   assign csr_ready  = 1'b1;

   assign is_sample = (req_data.opcode == OP_SAMPLE);
   assign sample    = req_data.sample_value[STORE_BITS-1:0];

   // The first matching slot wins, in the order a, b, c.
   always_comb begin
      hit  = 1'b1;
      slot = '0;
      if (req_data.channel == slot_a_ff) begin
         slot = SLOT_W'(0);
      end else if (req_data.channel == slot_b_ff) begin
         slot = SLOT_W'(1);
      end else if (req_data.channel == slot_c_ff) begin
         slot = SLOT_W'(2);
      end else begin
         hit = 1'b0;
      end
   end

   assign full = (level_ff[slot] == LVL_W'(QUEUE_DEPTH));
   assign drop = hit && full;

   // A triple can only complete on a push into the one slot that was empty, so the
   // pushed slot's value comes straight from the request word.
   always_comb begin
      triple = hit;
      for (int t = 0; t < SLOT_COUNT; t++) begin
         if (SLOT_W'(t) != slot && level_ff[t] == '0) begin
            triple = 1'b0;
         end
      end
   end

   always_comb begin
      for (int t = 0; t < SLOT_COUNT; t++) begin
         rd_ptr_in[t] = rd_ptr_ff[t];
         wr_ptr_in[t] = wr_ptr_ff[t];
         level_in[t]  = level_ff[t];
         if (accept) begin
            if (!is_sample) begin
               rd_ptr_in[t] = '0;
               wr_ptr_in[t] = '0;
               level_in[t]  = '0;
            end else begin
               if (hit && SLOT_W'(t) == slot) begin
                  wr_ptr_in[t] = advance(wr_ptr_ff[t]);
                  if (full) begin
                     rd_ptr_in[t] = advance(rd_ptr_ff[t]);
                  end else if (!triple) begin
                     level_in[t] = level_ff[t] + LVL_W'(1);
                  end
               end
               if (triple) begin
                  rd_ptr_in[t] = advance(rd_ptr_ff[t]);
                  if (SLOT_W'(t) != slot) begin
                     level_in[t] = level_ff[t] - LVL_W'(1);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      sample_cnt_in  = sample_cnt_ff;
      reject_cnt_in  = reject_cnt_ff;
      anomaly_cnt_in = anomaly_cnt_ff;
      if (accept && is_sample) begin
         sample_cnt_in = sample_cnt_ff + CNT_BITS'(1);
         if (!hit) begin
            reject_cnt_in = reject_cnt_ff + CNT_BITS'(1);
         end
         if (drop) begin
            anomaly_cnt_in = anomaly_cnt_ff + CNT_BITS'(1);
         end
      end
   end

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
      acta_ram #(
         .WIDTH (STORE_BITS),
         .DEPTH (QUEUE_DEPTH)
      ) u_store (
         .clock   (clock),
         .wr_en   (accept && is_sample && hit && slot == SLOT_W'(g)),
         .wr_addr (wr_ptr_ff[g]),
         .wr_data (sample),
         .rd_en   (accept),
         .rd_addr (rd_ptr_ff[g]),
         .rd_data (head_q[g])
      );
   end

   always_comb begin
      for (int t = 0; t < SLOT_COUNT; t++) begin
         raw[t] = '0;
         if (s1_triple_ff) begin
            raw[t] = (s1_slot_ff == SLOT_W'(t)) ? RAW_BITS'(s1_sample_ff)
                                                : RAW_BITS'(head_q[t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_a_ff <= SLOT_A_RESET;
         slot_b_ff <= SLOT_B_RESET;
         slot_c_ff <= SLOT_C_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOT_A: slot_a_ff <= csr_data;
            CSR_SLOT_B: slot_b_ff <= csr_data;
            CSR_SLOT_C: slot_c_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < SLOT_COUNT; t++) begin
            rd_ptr_ff[t] <= '0;
            wr_ptr_ff[t] <= '0;
            level_ff[t]  <= '0;
         end
         sample_cnt_ff  <= '0;
         reject_cnt_ff  <= '0;
         anomaly_cnt_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         level_ff       <= level_in;
         sample_cnt_ff  <= sample_cnt_in;
         reject_cnt_ff  <= reject_cnt_in;
         anomaly_cnt_ff <= anomaly_cnt_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance_s2) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance_s2) begin
            s2_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_triple_ff <= is_sample && triple;
         s1_reject_ff <= is_sample && !hit;
         s1_drop_ff   <= is_sample && drop;
         s1_slot_ff   <= slot;
         s1_sample_ff <= sample;
      end
      // The counters always belong to the word in the read stage, since no newer
      // word can be taken while it waits there.
      if (advance_s2) begin
         s2_data_ff.triple_valid    <= s1_triple_ff;
         s2_data_ff.first_raw       <= raw[0];
         s2_data_ff.second_raw      <= raw[1];
         s2_data_ff.third_raw       <= raw[2];
         s2_data_ff.sample_rejected <= s1_reject_ff;
         s2_data_ff.oldest_dropped  <= s1_drop_ff;
         s2_data_ff.samples_seen    <= sample_cnt_ff;
         s2_data_ff.rejected_total  <= reject_cnt_ff;
         s2_data_ff.anomaly_total   <= anomaly_cnt_ff;
      end
   end

   // A complete triple is always popped at once, so all three queues never hold data.
   a_never_all_filled: assert property (@(posedge clock) disable iff (reset)
      !(level_ff[0] != '0 && level_ff[1] != '0 && level_ff[2] != '0))
      else $error("all three slot queues hold samples after an update");

   a_triple_excludes_flags: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_triple_ff |-> !s1_drop_ff && !s1_reject_ff)
      else $error("triple reported together with a drop or a reject");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("request stalled while the pipeline has room");

   a_ptrs_match_level: assert property (@(posedge clock) disable iff (reset)
      (level_ff[0] == '0 || level_ff[0] == LVL_W'(QUEUE_DEPTH)) |->
      rd_ptr_ff[0] == wr_ptr_ff[0])
      else $error("first slot pointers disagree with its fill level");

endmodule
